>>> rtl/core/imsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imsa_pkg
// Shared types and constants for the indexed mesh surface area unit.
// ----------------------------------------------------------------------------
package imsa_pkg;

  localparam int AREA_W = 35;
  localparam int SUM_W  = 52;

  localparam logic ACT_VERTEX   = 1'b0;
  localparam logic ACT_TRIANGLE = 1'b1;

  typedef struct packed {
    logic              action;
    logic [9:0]        vertex_slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [9:0]        corner_a;
    logic [9:0]        corner_b;
    logic [9:0]        corner_c;
    logic              last_triangle;
  } imsa_in_t;

  typedef struct packed {
    logic [AREA_W-1:0] triangle_double_area;
    logic [SUM_W-1:0]  total_area;
    logic              sum_saturated;
  } imsa_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_WAIT_C, ST_EDGE, ST_CROSS, ST_SQ,
    ST_ROOT, ST_ACC, ST_OUT
  } imsa_state_t;

endpackage
`default_nettype wire

>>> rtl/core/indexed_mesh_surface_area_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_mesh_surface_area_unit
// Vertex store plus a sequential cross product, square root and saturating
// area accumulator.
// ----------------------------------------------------------------------------
// Usage. Items enter on in_data/in_valid/in_ready and results leave on
// out_data/out_valid/out_ready. A vertex item (action 0) writes one entry of
// the vertex memory in the cycle it is accepted and gives no result; the
// input stays ready for the next item. A triangle item (action 1) reads its
// three corners from the vertex memory one after another, forms the edges,
// the cross product and the squared length in registered steps, then runs a
// restoring square root one result bit per cycle. The root has 2*COORD_BITS+3
// bits. The input is ready again in the cycle the result becomes valid, so a
// new item is taken only once the triangle before it is finished. The result
// waits in the output register while out_ready is low; vertex items are still
// taken meanwhile, and a following triangle runs up to the accumulate step
// and waits there, holding in_ready low. Reset clears the control state, the
// running sum and the saturation flag; the vertex memory is not cleared, and
// reading a corner never written gives an unspecified area. A last-triangle
// item clears the sum after its result is formed.
// ----------------------------------------------------------------------------
module indexed_mesh_surface_area_unit #(
  parameter int VERTEX_COUNT = 1024,
  parameter int COORD_BITS   = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  imsa_pkg::imsa_in_t  in_data,
  input  wire                 in_valid,
  output logic                in_ready,
  output imsa_pkg::imsa_out_t out_data,
  output logic                out_valid,
  input  wire                 out_ready
);
  import imsa_pkg::*;

  localparam int AW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;          // edge component
  localparam int PW  = 2 * DW + 1;      // cross product component
  localparam int MW  = 2 * DW;          // its magnitude
  localparam int QW  = 2 * MW + 2;      // squared length sum
  localparam int RW  = QW / 2;          // root width
  localparam int CNTW = $clog2(RW + 1);

  // Vertex memory, one entry per vertex, x/y/z packed.
  logic [3*CW-1:0] vmem [VERTEX_COUNT];
  logic [3*CW-1:0] vrd;
  logic [AW-1:0]   raddr;
  logic            rd_oob;
  logic            rd_oob_q;

  imsa_state_t state, state_next;
  imsa_in_t    item;
  logic signed [CW-1:0] ax, ay, az, bx, by, bz;
  logic signed [PW-1:0] px, py, pz;
  logic [QW-1:0]   rad;
  logic [QW-1:0]   rem;
  logic [RW-1:0]   root;
  logic [CNTW-1:0] cnt;
  logic [SUM_W-1:0] area_sum;
  logic            sum_overflowed;
  imsa_out_t       res;
  logic            res_valid;

  logic            accept_in;
  logic            acc_go;
  logic [AREA_W-1:0] area_sat;
  logic [SUM_W:0]  sum_wide;
  logic [QW+1:0]   trial;
  logic [QW-1:0]   rem_sh;

  assign accept_in = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = res_valid;
  assign out_data  = res;

  // The accumulate step may only load the output register once it is free
  // or being emptied in the same cycle.
  assign acc_go = (state == ST_ACC) && (!res_valid || out_ready);

  // Vertex write port and read port.
  logic [AW-1:0] waddr;
  logic          wr_ok;
  always_comb begin
    waddr = AW'(in_data.vertex_slot);
    wr_ok = ({22'd0, in_data.vertex_slot} < 32'(VERTEX_COUNT));
  end

  always_ff @(posedge clk) begin
    if (accept_in && in_data.action == ACT_VERTEX && wr_ok) begin
      vmem[waddr] <= {CW'(in_data.pos_x), CW'(in_data.pos_y),
                      CW'(in_data.pos_z)};
    end
    vrd      <= vmem[raddr];
    rd_oob_q <= rd_oob;
  end

  always_comb begin
    logic [9:0] idx;
    case (state)
      ST_RD_A: idx = item.corner_a;
      ST_RD_B: idx = item.corner_b;
      default: idx = item.corner_c;
    endcase
    raddr  = AW'(idx);
    rd_oob = ({22'd0, idx} >= 32'(VERTEX_COUNT));
  end

  logic signed [CW-1:0] rx, ry, rz;
  always_comb begin
    rx = rd_oob_q ? '0 : vrd[3*CW-1:2*CW];
    ry = rd_oob_q ? '0 : vrd[2*CW-1:CW];
    rz = rd_oob_q ? '0 : vrd[CW-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept_in && in_data.action == ACT_TRIANGLE) state_next = ST_RD_A;
      ST_RD_A:   state_next = ST_RD_B;
      ST_RD_B:   state_next = ST_RD_C;
      ST_RD_C:   state_next = ST_WAIT_C;
      ST_WAIT_C: state_next = ST_EDGE;
      ST_EDGE:   state_next = ST_CROSS;
      ST_CROSS:  state_next = ST_SQ;
      ST_SQ:     state_next = ST_ROOT;
      ST_ROOT:   if (cnt == CNTW'(RW - 1)) state_next = ST_ACC;
      ST_ACC:    if (!res_valid || out_ready) state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Restoring square root step: two radicand bits per cycle, one root bit.
  always_comb begin
    rem_sh = {rem[QW-3:0], rad[QW-1:QW-2]};
    trial  = {2'b00, rem_sh} - {{(QW+2-RW-2){1'b0}}, root, 2'b01};
  end

  // Areas beyond the result width saturate.
  always_comb begin
    if (RW > AREA_W && |(root >> AREA_W)) area_sat = '1;
    else                                   area_sat = AREA_W'(root);
    sum_wide = {1'b0, area_sum} + (SUM_W+1)'(area_sat);
  end

  // Read data is registered, so corner A is on the read port in ST_RD_B and
  // corner B in ST_RD_C.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (accept_in) item <= in_data;
      ST_RD_B: begin
        ax <= rx; ay <= ry; az <= rz;
      end
      ST_RD_C: begin
        bx <= rx; by <= ry; bz <= rz;
      end
      default: ;
    endcase
  end

  // Corner C arrives in ST_WAIT_C; hold it.
  logic signed [CW-1:0] cxh, cyh, czh;
  always_ff @(posedge clk) begin
    if (state == ST_WAIT_C) begin
      cxh <= rx; cyh <= ry; czh <= rz;
    end
  end

  // Products computed one component per state would cost cycles; the six
  // narrow multiplies stand in parallel, registered before squaring.
  logic signed [DW-1:0] ux2, uy2, uz2, vx2, vy2, vz2;
  always_ff @(posedge clk) begin
    if (state == ST_CROSS) begin
      ux2 <= DW'(bx) - DW'(ax); uy2 <= DW'(by) - DW'(ay); uz2 <= DW'(bz) - DW'(az);
      vx2 <= DW'(cxh) - DW'(ax); vy2 <= DW'(cyh) - DW'(ay); vz2 <= DW'(czh) - DW'(az);
    end
    if (state == ST_SQ) begin
      px <= PW'(uy2 * vz2) - PW'(uz2 * vy2);
      py <= PW'(uz2 * vx2) - PW'(ux2 * vz2);
      pz <= PW'(ux2 * vy2) - PW'(uy2 * vx2);
    end
  end

  logic [MW-1:0] mx, my, mz;
  always_comb begin
    mx = MW'(px[PW-1] ? -px : px);
    my = MW'(py[PW-1] ? -py : py);
    mz = MW'(pz[PW-1] ? -pz : pz);
  end

  // Squares are taken on the first root cycle, so the root starts in the next
  // cycle; cnt counts root bits with the first cycle as setup.
  logic sq_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      area_sum       <= '0;
      sum_overflowed <= 1'b0;
      res_valid      <= 1'b0;
      sq_done        <= 1'b0;
      cnt            <= '0;
    end else begin
      if (state == ST_SQ) begin
        sq_done <= 1'b0;
        cnt     <= '0;
      end else if (state == ST_ROOT) begin
        if (!sq_done) begin
          sq_done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (state == ST_OUT) begin
        res_valid <= 1'b1;
        if (item.last_triangle) begin
          area_sum       <= '0;
          sum_overflowed <= 1'b0;
        end
      end else if (acc_go) begin
        if (sum_wide[SUM_W]) begin
          area_sum       <= '1;
          sum_overflowed <= 1'b1;
        end else begin
          area_sum <= sum_wide[SUM_W-1:0];
        end
      end
      if (out_valid && out_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROOT && !sq_done) begin
      rad  <= QW'({MW'(0), mx} * {MW'(0), mx}) + QW'({MW'(0), my} * {MW'(0), my})
            + QW'({MW'(0), mz} * {MW'(0), mz});
      rem  <= '0;
      root <= '0;
    end else if (state == ST_ROOT) begin
      rad <= {rad[QW-3:0], 2'b00};
      if (!trial[QW+1]) begin
        rem  <= trial[QW-1:0];
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RW-2:0], 1'b0};
      end
    end
    if (acc_go) begin
      res.triangle_double_area <= area_sat;
      res.total_area           <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      res.sum_saturated        <= sum_wide[SUM_W] | sum_overflowed;
    end
  end

  // Hold root loop until the last bit: extend ST_ROOT by the setup cycle.
  // (cnt reaches RW-1 only after sq_done, so RW bits are produced.)

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_sat_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sum_saturated |-> out_data.total_area == '1)
    else $error("saturated flag without full sum");
  a_valid_after_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |=> out_valid)
    else $error("result lost");
  a_acc_wait: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC && out_valid && !out_ready |=> state == ST_ACC)
    else $error("accumulate step ran over a waiting result");
`endif

endmodule
`default_nettype wire

>>> tb/indexed_mesh_surface_area_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_mesh_surface_area_unit_tb
// Self-checking bench for the mesh surface area unit. Vertex and triangle
// items are driven through the input handshake. A scoreboard keeps its own
// copy of the vertex store and the running sum, works out each expected
// triangle result, and compares every result leaving the block with it.
// ----------------------------------------------------------------------------
module indexed_mesh_surface_area_unit_tb;
  import imsa_pkg::*;

  localparam int          MAX_CYCLES = 3000000;
  localparam logic [34:0] AREA_CAP   = {35{1'b1}};
  localparam logic [51:0] SUM_CAP    = {52{1'b1}};

  // Scoreboard: holds the expected block state and the queue of pending
  // results, and counts mismatches.
  class mesh_area_scoreboard;
    logic signed [15:0] vx[1024], vy[1024], vz[1024];
    bit                 vtx_written[1024];
    logic [51:0]        area_sum;
    bit                 overflowed;
    imsa_out_t          pending[$];
    int                 mismatches;
    int                 checked;

    function void note_item(imsa_in_t it);
      logic signed [16:0] ux, uy, uz, wx, wy, wz;
      logic signed [34:0] px, py, pz;
      logic [69:0]        sq;
      logic [71:0]        trial;
      logic [52:0]        sum;
      logic [35:0]        root;
      imsa_out_t          res;
      if (it.action == ACT_VERTEX) begin
        vx[it.vertex_slot] = it.pos_x;
        vy[it.vertex_slot] = it.pos_y;
        vz[it.vertex_slot] = it.pos_z;
        vtx_written[it.vertex_slot] = 1;
        return;
      end
      ux = 17'(vx[it.corner_b]) - 17'(vx[it.corner_a]);
      uy = 17'(vy[it.corner_b]) - 17'(vy[it.corner_a]);
      uz = 17'(vz[it.corner_b]) - 17'(vz[it.corner_a]);
      wx = 17'(vx[it.corner_c]) - 17'(vx[it.corner_a]);
      wy = 17'(vy[it.corner_c]) - 17'(vy[it.corner_a]);
      wz = 17'(vz[it.corner_c]) - 17'(vz[it.corner_a]);
      px = 35'(uy) * 35'(wz) - 35'(uz) * 35'(wy);
      py = 35'(uz) * 35'(wx) - 35'(ux) * 35'(wz);
      pz = 35'(ux) * 35'(wy) - 35'(uy) * 35'(wx);
      sq = 70'(70'(px) * 70'(px)) + 70'(70'(py) * 70'(py)) + 70'(70'(pz) * 70'(pz));
      // Bitwise floor square root; the trial square needs 72 bits.
      root = 0;
      for (int b = 35; b >= 0; b--) begin
        trial = 72'(root | (36'd1 << b));
        if (trial * trial <= 72'(sq)) root = root | (36'd1 << b);
      end
      if (root > 36'(AREA_CAP)) root = 36'(AREA_CAP);
      sum = 53'(area_sum) + 53'(root);
      if (sum > 53'(SUM_CAP)) begin
        sum = 53'(SUM_CAP);
        overflowed = 1;
      end
      area_sum = sum[51:0];
      res.triangle_double_area = root[34:0];
      res.total_area = area_sum;
      res.sum_saturated = overflowed;
      pending.push_back(res);
      if (it.last_triangle) begin
        area_sum = 0;
        overflowed = 0;
      end
    endfunction

    function void check_result(imsa_out_t got);
      imsa_out_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", got);
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      if (got !== exp_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: area exp %0d got %0d, total exp %0d got %0d, sat exp %0b got %0b",
                   exp_res.triangle_double_area, got.triangle_double_area,
                   exp_res.total_area, got.total_area,
                   exp_res.sum_saturated, got.sum_saturated);
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  imsa_in_t  in_data = '0;
  logic      in_valid = 0;
  logic      in_ready;
  imsa_out_t out_data;
  logic      out_valid;
  logic      out_ready = 0;

  mesh_area_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  int  cycle_count = 0;
  int  vertex_items = 0;
  int  triangle_items = 0;
  int  slot_hi = 1023;

  always #5 clk = ~clk;

  indexed_mesh_surface_area_unit dut (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid),
    .in_ready(in_ready), .out_data(out_data), .out_valid(out_valid),
    .out_ready(out_ready)
  );

  // Receiver: random stalls, plus a long hold-off on request. Results are
  // checked at the edge where they are taken.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (rst) out_ready <= 0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one item, with a random gap first, and waits for acceptance.
  // Valid stays high after acceptance until a gap or a drain drops it.
  task automatic send_item(imsa_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    if (it.action == ACT_VERTEX) vertex_items++;
    else triangle_items++;
  endtask

  task automatic put_vertex(int slot, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    imsa_in_t it;
    it = imsa_in_t'(90'({$urandom, $urandom, $urandom}));
    it.action = ACT_VERTEX;
    it.vertex_slot = slot[9:0];
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    send_item(it);
  endtask

  // Picks a slot that already holds a vertex.
  function automatic logic [9:0] written_slot();
    logic [9:0] s;
    do s = 10'($urandom_range(slot_hi)); while (!sb.vtx_written[s]);
    return s;
  endfunction

  task automatic put_triangle(logic [9:0] a, logic [9:0] b, logic [9:0] c, bit last);
    imsa_in_t it;
    it = imsa_in_t'(90'({$urandom, $urandom, $urandom}));
    it.action = ACT_TRIANGLE;
    it.corner_a = a;
    it.corner_b = b;
    it.corner_c = c;
    it.last_triangle = last;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'h8000 + 16'($urandom_range(3));
      1: return 16'h7FFF - 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // One mesh: a few fresh vertices, then triangles over written slots,
  // the last one marked.
  task automatic random_mesh();
    int nv, nt;
    nv = $urandom_range(1, 4);
    nt = $urandom_range(1, 6);
    for (int i = 0; i < nv; i++)
      put_vertex($urandom_range(slot_hi), rand_coord(), rand_coord(), rand_coord());
    for (int i = 0; i < nt; i++)
      put_triangle(written_slot(), written_slot(), written_slot(), i == nt - 1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: corner slots, extreme coordinates, degenerate and
    // repeated corners, largest possible area, and a long mesh.
    put_vertex(0, 16'h0000, 16'h0000, 16'h0000);
    put_vertex(1023, 16'h7FFF, 16'h8000, 16'h7FFF);
    put_vertex(1, 16'h8000, 16'h7FFF, 16'h8000);
    put_vertex(2, 16'h0100, 16'h0000, 16'h0000);
    put_vertex(3, 16'h0000, 16'h0100, 16'h0000);
    put_vertex(4, 16'h7FFF, 16'h7FFF, 16'h8000);
    put_vertex(5, 16'h8000, 16'h8000, 16'h7FFF);
    put_triangle(0, 2, 3, 0);
    put_triangle(0, 0, 0, 0);
    put_triangle(1023, 1023, 1, 0);
    put_triangle(1023, 1, 4, 0);
    put_triangle(1, 4, 5, 1);
    put_triangle(2, 3, 0, 1);
    // Many maximal triangles in one mesh build up a large sum.
    for (int i = 0; i < 12; i++) put_triangle(1023, 1, 4, 0);
    put_triangle(1023, 1, 4, 1);
    put_triangle(0, 2, 3, 1);
    wait_drained();

    // Receiver holds off for a long stretch while items keep coming.
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 4; i++) random_mesh();
    join
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 25 : 0;
      recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 25 : 0;
      slot_hi = (ph[0]) ? 15 : 1023;
      while (vertex_items + triangle_items < 285 * (ph + 1)) begin
        if ($urandom_range(9) == 0)
          put_vertex($urandom_range(slot_hi), 16'($urandom), 16'($urandom), 16'($urandom));
        else
          random_mesh();
      end
      // Sender pauses until everything is back.
      wait_drained();
    end

    wait_drained();
    repeat (60) @(posedge clk);
    $display("Covered %0d vertex writes and %0d triangles, %0d results checked.",
             vertex_items, triangle_items, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> indexed_mesh_surface_area_unit.f
rtl/core/imsa_pkg.sv
rtl/core/indexed_mesh_surface_area_unit.sv
tb/indexed_mesh_surface_area_unit_tb.sv
